// File: hw/rtl/rcmq_pkg.sv
// Shared types and constants for the range calibrate / median / quality block.
package rcmq_pkg;

	// Field widths.
	localparam int DATA_W = 16;
	localparam int RATE_W = 5;
	localparam int QUAL_W = 7;
	localparam int CNT_W  = 32;
	localparam int REG_W  = 3;

	// Default window depth.
	localparam int WINDOW_DEF = 8;

	// Configuration register indexes.
	localparam logic [REG_W-1:0] REG_CAL_OFFSET = 3'd0;
	localparam logic [REG_W-1:0] REG_CAL_SCALE  = 3'd1;
	localparam logic [REG_W-1:0] REG_RANGE_MIN  = 3'd2;
	localparam logic [REG_W-1:0] REG_RANGE_MAX  = 3'd3;
	localparam logic [REG_W-1:0] REG_CHANGE_THR = 3'd4;

	// Configuration reset values.
	localparam logic [DATA_W-1:0] RST_CAL_OFFSET = 16'd0;
	localparam logic [DATA_W-1:0] RST_CAL_SCALE  = 16'd256;
	localparam logic [DATA_W-1:0] RST_RANGE_MIN  = 16'd30;
	localparam logic [DATA_W-1:0] RST_RANGE_MAX  = 16'd2000;
	localparam logic [DATA_W-1:0] RST_CHANGE_THR = 16'd50;

	// Quality grades and the signal rate thresholds that select them.
	localparam logic [QUAL_W-1:0] QUAL_NONE = 7'd0;
	localparam logic [QUAL_W-1:0] QUAL_LOW  = 7'd25;
	localparam logic [QUAL_W-1:0] QUAL_MID  = 7'd50;
	localparam logic [QUAL_W-1:0] QUAL_GOOD = 7'd75;
	localparam logic [QUAL_W-1:0] QUAL_BEST = 7'd100;
	localparam logic [RATE_W-1:0] RATE_LOW  = 5'd2;
	localparam logic [RATE_W-1:0] RATE_MID  = 5'd5;
	localparam logic [RATE_W-1:0] RATE_GOOD = 5'd10;

	// Control from the sequencer to the rank unit.
	typedef struct packed {
		logic load;       // take the read entry as the candidate, clear the rank
		logic step;       // compare the read entry against the candidate
		logic lower_idx;  // the read entry sits at a lower index than the candidate
	} rank_ctl_t;

endpackage

// File: hw/rtl/range_calibrate_median_quality.sv
// Top level: calibration, sequencer for the window median, grading and output register.
// Each reading is taken as one transaction and yields one result transaction. A timed-out
// reading goes from accept straight to the load of a free output register. A valid reading
// passes accept, multiply and calibrate/store, then a rank scan on one shared comparator,
// then the load of a free output register. With an empty window the scan is a single check;
// otherwise each nonzero candidate is ranked against every entry, zero entries are skipped,
// and the scan stops at the median. The input stalls from accept until the result is loaded
// into the output register; a result waiting there does not block the next reading.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while no reading is in flight, which the block itself does not enforce.
module range_calibrate_median_quality #(
	parameter int WINDOW = rcmq_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic [rcmq_pkg::REG_W-1:0]  cfg_index,
	input  logic [rcmq_pkg::DATA_W-1:0] cfg_data,
	// Input channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rcmq_pkg::DATA_W-1:0] raw_mm,
	input  logic                        timed_out,
	input  logic [rcmq_pkg::RATE_W-1:0] signal_rate,
	// Output channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rcmq_pkg::DATA_W-1:0] calibrated_mm,
	output logic [rcmq_pkg::DATA_W-1:0] median_mm,
	output logic [rcmq_pkg::QUAL_W-1:0] quality,
	output logic                        range_valid,
	output logic                        big_change,
	output logic [rcmq_pkg::CNT_W-1:0]  total_count,
	output logic [rcmq_pkg::CNT_W-1:0]  valid_count,
	output logic [rcmq_pkg::CNT_W-1:0]  timeout_count
);
	import rcmq_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int NZ_W  = $clog2(WINDOW + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_CAL  = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_CHK  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;

	// Configuration registers.
	logic [DATA_W-1:0] cal_offset_q, cal_scale_q, range_min_q, range_max_q, change_thr_q;

	// Item and filter state.
	logic [DATA_W-1:0]   raw_q;
	logic [RATE_W-1:0]   rate_q;
	logic [2*DATA_W-1:0] prod_q;
	logic [DATA_W-1:0]   cur_q, prev_q, filt_q;
	logic [QUAL_W-1:0]   qual_q;
	logic [CNT_W-1:0]    total_q, valid_q, tmo_q;
	logic [IDX_W-1:0]    wp_q, i_q, j_q;

	// Output register.
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_cal_q, out_filt_q;
	logic [QUAL_W-1:0]   out_qual_q;
	logic                out_big_q;
	logic [CNT_W-1:0]    out_total_q, out_valid_cnt_q, out_tmo_q;

	logic                in_acc, out_acc, out_load;
	logic [IDX_W-1:0]    win_addr;
	logic                win_we;
	logic [DATA_W-1:0]   win_rd;
	logic [NZ_W-1:0]     nz_count;
	rank_ctl_t           rank_ctl;
	logic [DATA_W-1:0]   cand;
	logic [NZ_W-1:0]     rank;
	logic signed [DATA_W+9:0] cal_sum;
	logic [DATA_W-1:0]   cal_val;
	logic [QUAL_W-1:0]   grade;
	logic [DATA_W-1:0]   diff;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Window port address: write slot, candidate or compared entry.
	always_comb begin
		case (state_q)
			S_CAL:   win_addr = wp_q;
			S_LOAD:  win_addr = i_q;
			default: win_addr = j_q;
		endcase
	end
	assign win_we = (state_q == S_CAL);

	assign rank_ctl.load      = (state_q == S_LOAD);
	assign rank_ctl.step      = (state_q == S_CMP);
	assign rank_ctl.lower_idx = (j_q < i_q);

	rcmq_window #(.WINDOW(WINDOW), .IDX_W(IDX_W), .NZ_W(NZ_W)) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (win_addr),
		.wr_en    (win_we),
		.wr_data  (cal_val),
		.rd_data  (win_rd),
		.nz_count (nz_count)
	);

	rcmq_rank #(.WINDOW(WINDOW), .NZ_W(NZ_W)) u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rank_ctl),
		.rd_data (win_rd),
		.cand    (cand),
		.rank    (rank)
	);

	// Scaled reading plus signed offset, clamped to the 16-bit range.
	always_comb begin
		cal_sum = $signed({2'b00, prod_q[2*DATA_W-1:8]}) +
			(DATA_W+10)'($signed(cal_offset_q));
		if (cal_sum < 0) begin
			cal_val = '0;
		end else if (cal_sum > $signed((DATA_W+10)'(16'hFFFF))) begin
			cal_val = '1;
		end else begin
			cal_val = cal_sum[DATA_W-1:0];
		end
	end

	// Quality grade of the fresh calibrated value.
	always_comb begin
		if ((cal_val < range_min_q) || (cal_val > range_max_q)) begin
			grade = QUAL_NONE;
		end else if (rate_q < RATE_LOW) begin
			grade = QUAL_LOW;
		end else if (rate_q < RATE_MID) begin
			grade = QUAL_MID;
		end else if (rate_q < RATE_GOOD) begin
			grade = QUAL_GOOD;
		end else begin
			grade = QUAL_BEST;
		end
	end

	// Distance between the filtered and previous range.
	assign diff = (filt_q >= prev_q) ? (filt_q - prev_q) : (prev_q - filt_q);

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_offset_q <= RST_CAL_OFFSET;
			cal_scale_q  <= RST_CAL_SCALE;
			range_min_q  <= RST_RANGE_MIN;
			range_max_q  <= RST_RANGE_MAX;
			change_thr_q <= RST_CHANGE_THR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL_OFFSET: cal_offset_q <= cfg_data;
				REG_CAL_SCALE:  cal_scale_q  <= cfg_data;
				REG_RANGE_MIN:  range_min_q  <= cfg_data;
				REG_RANGE_MAX:  range_max_q  <= cfg_data;
				REG_CHANGE_THR: change_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured reading and gain product.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q  <= raw_mm;
			rate_q <= signal_rate;
		end
		if (state_q == S_MUL) begin
			prod_q <= (2*DATA_W)'(raw_q) * (2*DATA_W)'(cal_scale_q);
		end
	end

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			prev_q  <= '0;
			filt_q  <= '0;
			qual_q  <= QUAL_NONE;
			total_q <= '0;
			valid_q <= '0;
			tmo_q   <= '0;
			wp_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						total_q <= total_q + CNT_W'(1);
						if (timed_out) begin
							tmo_q   <= tmo_q + CNT_W'(1);
							qual_q  <= QUAL_NONE;
							state_q <= S_OUT;
						end else begin
							valid_q <= valid_q + CNT_W'(1);
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_CAL;
				end
				S_CAL: begin
					prev_q  <= cur_q;
					cur_q   <= cal_val;
					qual_q  <= grade;
					wp_q    <= (wp_q == LAST_IDX) ? '0 : wp_q + IDX_W'(1);
					i_q     <= '0;
					j_q     <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// With no nonzero entry the current range passes straight through.
					if (nz_count == '0) begin
						filt_q  <= cur_q;
						state_q <= S_OUT;
					end else if (win_rd == '0) begin
						i_q <= i_q + IDX_W'(1);
					end else begin
						j_q     <= '0;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (j_q == LAST_IDX) begin
						j_q     <= '0;
						state_q <= S_CHK;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_CHK: begin
					if (rank == (nz_count >> 1)) begin
						filt_q  <= cand;
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_LOAD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cal_q       <= cur_q;
			out_filt_q      <= filt_q;
			out_qual_q      <= qual_q;
			out_big_q       <= (diff > change_thr_q);
			out_total_q     <= total_q;
			out_valid_cnt_q <= valid_q;
			out_tmo_q       <= tmo_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign calibrated_mm = out_cal_q;
	assign median_mm     = out_filt_q;
	assign quality       = out_qual_q;
	assign range_valid   = (out_qual_q != QUAL_NONE);
	assign big_change    = out_big_q;
	assign total_count   = out_total_q;
	assign valid_count   = out_valid_cnt_q;
	assign timeout_count = out_tmo_q;

endmodule

// File: hw/rtl/rcmq_window.sv
// Ring window of calibrated readings with a running count of nonzero entries.
module rcmq_window #(
	parameter int WINDOW = rcmq_pkg::WINDOW_DEF,
	parameter int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
	parameter int NZ_W   = $clog2(WINDOW + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IDX_W-1:0]          addr,
	input  logic                      wr_en,
	input  logic [rcmq_pkg::DATA_W-1:0] wr_data,
	output logic [rcmq_pkg::DATA_W-1:0] rd_data,
	output logic [NZ_W-1:0]           nz_count
);
	import rcmq_pkg::*;

	logic [DATA_W-1:0] store_q [WINDOW];
	logic [NZ_W-1:0]   nz_q;

	// One shared port: the read shows the entry about to be overwritten.
	assign rd_data  = store_q[addr];
	assign nz_count = nz_q;

	// Entry storage, cleared to empty at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				store_q[k] <= '0;
			end
		end else if (wr_en) begin
			store_q[addr] <= wr_data;
		end
	end

	// Nonzero count follows each overwrite.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (wr_en) begin
			if ((wr_data != '0) && (rd_data == '0)) begin
				nz_q <= nz_q + NZ_W'(1);
			end else if ((wr_data == '0) && (rd_data != '0)) begin
				nz_q <= nz_q - NZ_W'(1);
			end
		end
	end

endmodule

// File: hw/rtl/rcmq_rank.sv
// Shared compare unit that ranks one candidate entry against the window.
module rcmq_rank #(
	parameter int WINDOW = rcmq_pkg::WINDOW_DEF,
	parameter int NZ_W   = $clog2(WINDOW + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rcmq_pkg::rank_ctl_t         ctl,
	input  logic [rcmq_pkg::DATA_W-1:0] rd_data,
	output logic [rcmq_pkg::DATA_W-1:0] cand,
	output logic [NZ_W-1:0]             rank
);
	import rcmq_pkg::*;

	logic [DATA_W-1:0] cand_q;
	logic [NZ_W-1:0]   rank_q;
	logic              ahead;

	// An entry ranks ahead when it is nonzero and sorts before the candidate;
	// equal values are ordered by window index.
	assign ahead = (rd_data != '0) &&
		((rd_data < cand_q) || ((rd_data == cand_q) && ctl.lower_idx));

	assign cand = cand_q;
	assign rank = rank_q;

	// Candidate value.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cand_q <= rd_data;
		end
	end

	// Rank accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (ctl.load) begin
			rank_q <= '0;
		end else if (ctl.step && ahead) begin
			rank_q <= rank_q + NZ_W'(1);
		end
	end

endmodule

// File: hw/rtl/rcmq_chk.sv
// Port-level checker for the range calibrate / median / quality block, with its bind.
module rcmq_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [rcmq_pkg::DATA_W-1:0] calibrated_mm,
	input logic [rcmq_pkg::QUAL_W-1:0] quality,
	input logic [rcmq_pkg::CNT_W-1:0]  total_count,
	input logic [rcmq_pkg::CNT_W-1:0]  valid_count,
	input logic [rcmq_pkg::CNT_W-1:0]  timeout_count
);
	import rcmq_pkg::*;

	// Every reading is counted either as valid or as timed out.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_count == valid_count + timeout_count))
		else $error("total count differs from valid plus timeout counts");

	// Only the defined grades appear.
	a_grade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((quality == QUAL_NONE) || (quality == QUAL_LOW) ||
			(quality == QUAL_MID) || (quality == QUAL_GOOD) || (quality == QUAL_BEST)))
		else $error("quality outside the defined grades");

	// The block works on one reading at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transaction");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(calibrated_mm) &&
			$stable(total_count)))
		else $error("stalled result changed");

endmodule

bind range_calibrate_median_quality rcmq_chk u_rcmq_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.calibrated_mm (calibrated_mm),
	.quality       (quality),
	.total_count   (total_count),
	.valid_count   (valid_count),
	.timeout_count (timeout_count)
);

// File: test/tb_top.sv
// Self-checking testbench for range_calibrate_median_quality: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
	import rcmq_pkg::*;

	// Run shape.
	localparam int  RAND_PHASES = 12;
	localparam int  PHASE_ITEMS = 157;
	localparam int  DRAIN_PAUSE = 100;
	localparam int  MAX_PRINTS  = 40;
	localparam longint MM_MAX   = 65535;

	// Indexes past the last register; writes there must be ignored.
	localparam logic [REG_W-1:0] REG_SPARE_LO = REG_CHANGE_THR + 1'b1;
	localparam logic [REG_W-1:0] REG_SPARE_HI = '1;

	typedef enum logic {ROW_READING, ROW_CONFIG} row_kind_e;

	// One row of the directed table: either a reading or a register write.
	typedef struct packed {
		row_kind_e          kind;
		logic [REG_W-1:0]   idx;     // register index, config rows only
		logic [DATA_W-1:0]  value;   // raw reading or register data
		logic               tmo;
		logic [RATE_W-1:0]  rate;
		logic               known;   // typed expectation present
		logic [DATA_W-1:0]  k_cal;
		logic [QUAL_W-1:0]  k_qual;
	} stim_row_t;

	// One expected result transaction.
	typedef struct packed {
		logic [DATA_W-1:0] cal_mm;
		logic [DATA_W-1:0] filt_mm;
		logic [QUAL_W-1:0] qual;
		logic              in_range;
		logic              moved;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  valid;
		logic [CNT_W-1:0]  timeouts;
	} reading_result_t;

	localparam int DIR_ROWS = 31;
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_READING, REG_CAL_OFFSET, 16'd1234,  1'b1, 5'd31, 1'b1, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd0,     1'b0, 5'd0,  1'b1, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd65535, 1'b0, 5'd31, 1'b1, 16'd65535, QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd30,    1'b0, 5'd1,  1'b1, 16'd30,    QUAL_LOW},
		'{ROW_READING, REG_CAL_OFFSET, 16'd2000,  1'b0, 5'd4,  1'b1, 16'd2000,  QUAL_MID},
		'{ROW_READING, REG_CAL_OFFSET, 16'd29,    1'b0, 5'd9,  1'b1, 16'd29,    QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd2001,  1'b0, 5'd10, 1'b1, 16'd2001,  QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd1000,  1'b0, 5'd2,  1'b1, 16'd1000,  QUAL_MID},
		'{ROW_READING, REG_CAL_OFFSET, 16'd500,   1'b0, 5'd5,  1'b1, 16'd500,   QUAL_GOOD},
		'{ROW_READING, REG_CAL_OFFSET, 16'd0,     1'b1, 5'd0,  1'b1, 16'd500,   QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd21845, 1'b0, 5'd21, 1'b1, 16'd21845, QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd43690, 1'b0, 5'd10, 1'b1, 16'd43690, QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd1500,  1'b0, 5'd31, 1'b1, 16'd1500,  QUAL_BEST},
		'{ROW_CONFIG,  REG_CAL_OFFSET, 16'h8000,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd100,   1'b0, 5'd3,  1'b1, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_CAL_SCALE,  16'hFFFF,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_CAL_OFFSET, 16'h7FFF,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd65535, 1'b0, 5'd31, 1'b1, 16'd65535, QUAL_NONE},
		'{ROW_CONFIG,  REG_CAL_SCALE,  16'd0,     1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_CAL_OFFSET, 16'd1000,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd12345, 1'b0, 5'd15, 1'b1, 16'd1000,  QUAL_BEST},
		'{ROW_CONFIG,  REG_RANGE_MIN,  16'd3000,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_RANGE_MAX,  16'd100,   1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd5000,  1'b0, 5'd31, 1'b1, 16'd1000,  QUAL_NONE},
		'{ROW_CONFIG,  REG_CHANGE_THR, 16'd0,     1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_SPARE_LO,   16'hFFFF,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_SPARE_HI,   16'h5A5A,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd7,     1'b1, 5'd7,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_CONFIG,  REG_CHANGE_THR, 16'hFFFF,  1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd1,     1'b0, 5'd0,  1'b0, 16'd0,     QUAL_NONE},
		'{ROW_READING, REG_CAL_OFFSET, 16'd0,     1'b0, 5'd16, 1'b0, 16'd0,     QUAL_NONE}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [REG_W-1:0]    cfg_index;
	logic [DATA_W-1:0]   cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [DATA_W-1:0]   raw_mm;
	logic                timed_out;
	logic [RATE_W-1:0]   signal_rate;
	logic                out_valid;
	logic                out_stall;
	logic [DATA_W-1:0]   calibrated_mm;
	logic [DATA_W-1:0]   median_mm;
	logic [QUAL_W-1:0]   quality;
	logic                range_valid;
	logic                big_change;
	logic [CNT_W-1:0]    total_count;
	logic [CNT_W-1:0]    valid_count;
	logic [CNT_W-1:0]    timeout_count;

	// Predictor configuration and state.
	logic [DATA_W-1:0]   offset_q, scale_q, min_q, max_q, thr_q;
	logic [DATA_W-1:0]   win_q [WINDOW_DEF];
	int                  win_pos;
	logic [DATA_W-1:0]   cur_mm, prev_mm, filt_mm;
	logic [QUAL_W-1:0]   qual_q;
	logic [CNT_W-1:0]    seen_total, seen_valid, seen_timeouts;

	reading_result_t     expected_results [$];
	int                  mismatch_count = 0;
	int                  results_checked = 0;
	bit                  calm_in = 1'b0;

	range_calibrate_median_quality u_top (.*);

	// Free-running clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Count a failure and print a bounded number of lines.
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS) begin
			$display("mismatch at result %0d: %s", results_checked, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// Advance the predictor by one reading and return the result it causes.
	task automatic grade_reading(input logic [DATA_W-1:0] raw, input logic tmo,
			input logic [RATE_W-1:0] rate, output reading_result_t res);
		logic [31:0]       prod;
		longint            sum;
		logic [DATA_W-1:0] sorted_vals [WINDOW_DEF];
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] diff;
		int                n;
		int                j;
		seen_total++;
		if (!tmo) begin
			seen_valid++;
			prev_mm = cur_mm;
			// Scale in Q8.8, truncate, add the signed offset, clamp to 16 bits.
			prod = 32'(raw) * 32'(scale_q);
			sum = longint'(prod >> 8) + longint'($signed(offset_q));
			if (sum < 0) begin
				cur_mm = '0;
			end else if (sum > MM_MAX) begin
				cur_mm = '1;
			end else begin
				cur_mm = sum[DATA_W-1:0];
			end
			win_q[win_pos] = cur_mm;
			win_pos = (win_pos + 1) % WINDOW_DEF;
			// Insertion sort of the nonzero window entries.
			n = 0;
			for (int i = 0; i < WINDOW_DEF; i++) begin
				if (win_q[i] != '0) begin
					key = win_q[i];
					j = n;
					while (j > 0 && sorted_vals[j-1] > key) begin
						sorted_vals[j] = sorted_vals[j-1];
						j--;
					end
					sorted_vals[j] = key;
					n++;
				end
			end
			filt_mm = (n == 0) ? cur_mm : sorted_vals[n/2];
			// Grade by limits, then by signal rate.
			if (cur_mm < min_q || cur_mm > max_q) begin
				qual_q = QUAL_NONE;
			end else if (rate < RATE_LOW) begin
				qual_q = QUAL_LOW;
			end else if (rate < RATE_MID) begin
				qual_q = QUAL_MID;
			end else if (rate < RATE_GOOD) begin
				qual_q = QUAL_GOOD;
			end else begin
				qual_q = QUAL_BEST;
			end
		end else begin
			seen_timeouts++;
			qual_q = QUAL_NONE;
		end
		diff = (filt_mm >= prev_mm) ? filt_mm - prev_mm : prev_mm - filt_mm;
		res.cal_mm   = cur_mm;
		res.filt_mm  = filt_mm;
		res.qual     = qual_q;
		res.in_range = (qual_q != QUAL_NONE);
		res.moved    = (diff > thr_q);
		res.total    = seen_total;
		res.valid    = seen_valid;
		res.timeouts = seen_timeouts;
	endtask

	// Write one register; called at a falling edge, returns at the next one with cfg_we high.
	task automatic write_register(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		case (idx)
			REG_CAL_OFFSET: offset_q = value;
			REG_CAL_SCALE:  scale_q  = value;
			REG_RANGE_MIN:  min_q    = value;
			REG_RANGE_MAX:  max_q    = value;
			REG_CHANGE_THR: thr_q    = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Let the block run dry before touching its registers.
	task automatic settle();
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Offer one reading after a random gap (none when calm_in is set) and record its expectation on acceptance.
	task automatic send_reading(input logic [DATA_W-1:0] raw, input logic tmo,
			input logic [RATE_W-1:0] rate, input logic known,
			input logic [DATA_W-1:0] k_cal, input logic [QUAL_W-1:0] k_qual);
		int              pick;
		int              gap;
		reading_result_t want;
		gap = 0;
		if (!calm_in) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) gap = 0;
			else if (pick < 85) gap = $urandom_range(1, 3);
			else if (pick < 97) gap = $urandom_range(4, 12);
			else gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		raw_mm      = raw;
		timed_out   = tmo;
		signal_rate = rate;
		in_valid    = 1'b1;
		do @(posedge clk); while (in_stall);
		grade_reading(raw, tmo, rate, want);
		if (known) begin
			want.cal_mm = k_cal;
			want.qual   = k_qual;
		end
		expected_results.push_back(want);
		@(negedge clk);
	endtask

	// Output stall: short and long stalls, with short and long free-running stretches between.
	initial begin
		int stall_hold;
		int pick;
		stall_hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				stall_hold--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					out_stall = 1'b0;
					stall_hold = $urandom_range(0, 6);
				end else if (pick < 60) begin
					out_stall = 1'b0;
					stall_hold = $urandom_range(50, 200);
				end else if (pick < 95) begin
					out_stall = 1'b1;
					stall_hold = $urandom_range(0, 3);
				end else begin
					out_stall = 1'b1;
					stall_hold = $urandom_range(10, 50);
				end
			end
		end
	end

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		reading_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = expected_results.pop_front();
				check_field("calibrated_mm", calibrated_mm, want.cal_mm);
				check_field("median_mm", median_mm, want.filt_mm);
				check_field("quality", quality, want.qual);
				check_field("range_valid", range_valid, want.in_range);
				check_field("big_change", big_change, want.moved);
				check_field("total_count", total_count, want.total);
				check_field("valid_count", valid_count, want.valid);
				check_field("timeout_count", timeout_count, want.timeouts);
			end
			results_checked++;
		end
	end

	// Hang guard, sized well above the slowest legal run.
	initial begin
		#6_400_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		int                mode;
		bit                ext;
		int                pick;
		logic [DATA_W-1:0] off_v, scale_v, min_v, max_v, thr_v;
		logic [DATA_W-1:0] raw_v;
		logic              tmo_v;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_CAL_OFFSET;
		cfg_data    = '0;
		in_valid    = 1'b0;
		raw_mm      = '0;
		timed_out   = 1'b0;
		signal_rate = '0;
		offset_q = RST_CAL_OFFSET;
		scale_q  = RST_CAL_SCALE;
		min_q    = RST_RANGE_MIN;
		max_q    = RST_RANGE_MAX;
		thr_q    = RST_CHANGE_THR;
		foreach (win_q[i]) win_q[i] = '0;
		win_pos = 0;
		cur_mm  = '0;
		prev_mm = '0;
		filt_mm = '0;
		qual_q  = QUAL_NONE;
		seen_total    = '0;
		seen_valid    = '0;
		seen_timeouts = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; register writes wait for the block to go idle.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CONFIG) begin
				if (!cfg_we) settle();
				write_register(directed_rows[r].idx, directed_rows[r].value);
			end else begin
				cfg_we = 1'b0;
				send_reading(directed_rows[r].value, directed_rows[r].tmo,
					directed_rows[r].rate, directed_rows[r].known,
					directed_rows[r].k_cal, directed_rows[r].k_qual);
			end
		end

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			settle();
			mode = phase % 4;
			ext  = (((phase / 4) % 2) != 0);
			case (mode)
				0: begin
					off_v   = DATA_W'($urandom_range(0, 400)) - 16'd200;
					scale_v = DATA_W'($urandom_range(200, 320));
					min_v   = DATA_W'($urandom_range(0, 100));
					max_v   = DATA_W'($urandom_range(1500, 3000));
					thr_v   = DATA_W'($urandom_range(0, 200));
				end
				1: begin
					off_v   = ext ? 16'h7FFF : 16'h8000;
					scale_v = ext ? '0 : '1;
					min_v   = ext ? '1 : '0;
					max_v   = ext ? '0 : '1;
					thr_v   = ext ? '1 : '0;
				end
				2: begin
					off_v   = DATA_W'($urandom);
					scale_v = DATA_W'($urandom);
					min_v   = DATA_W'($urandom);
					max_v   = DATA_W'($urandom);
					thr_v   = DATA_W'($urandom);
				end
				default: begin
					off_v   = RST_CAL_OFFSET;
					scale_v = RST_CAL_SCALE;
					min_v   = DATA_W'($urandom_range(0, 3000));
					max_v   = DATA_W'($urandom_range(0, 3000));
					pick    = $urandom_range(0, 2);
					thr_v   = (pick == 0) ? '0 : (pick == 1) ? '1 : DATA_W'($urandom_range(0, 500));
				end
			endcase
			write_register(REG_CAL_OFFSET, off_v);
			write_register(REG_CAL_SCALE, scale_v);
			write_register(REG_RANGE_MIN, min_v);
			write_register(REG_RANGE_MAX, max_v);
			write_register(REG_CHANGE_THR, thr_v);
			if ($urandom_range(0, 1)) begin
				write_register(REG_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					DATA_W'($urandom));
			end
			cfg_we  = 1'b0;
			calm_in = (phase % 3 == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) raw_v = '0;
				else if (pick < 14) raw_v = '1;
				else if (pick < 22) raw_v = DATA_W'($urandom);
				else raw_v = DATA_W'($urandom_range(1, 3000));
				tmo_v = ($urandom_range(0, 99) < 15);
				send_reading(raw_v, tmo_v, RATE_W'($urandom_range(0, 31)), 1'b0, '0,
					QUAL_NONE);
			end
		end

		// Drain, then allow for a late stray result.
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
